// File: sv/mnt_pkg.sv
`default_nettype none

package mnt_pkg;

    // Message kinds as reported on the result channel
    typedef enum logic [2:0] {
        KIND_NOTEOFF   = 3'd0,
        KIND_NOTEON    = 3'd1,
        KIND_POLYPRESS = 3'd2,
        KIND_CC        = 3'd3,
        KIND_PROGRAM   = 3'd4,
        KIND_CHANPRESS = 3'd5,
        KIND_BEND      = 3'd6,
        KIND_UNKNOWN   = 3'd7
    } mnt_kind_t;

    // High nibble of the status byte
    localparam logic [3:0] STAT_NOTEOFF   = 4'h8;
    localparam logic [3:0] STAT_NOTEON    = 4'h9;
    localparam logic [3:0] STAT_POLYPRESS = 4'hA;
    localparam logic [3:0] STAT_CC        = 4'hB;
    localparam logic [3:0] STAT_PROGRAM   = 4'hC;
    localparam logic [3:0] STAT_CHANPRESS = 4'hD;
    localparam logic [3:0] STAT_BEND      = 4'hE;

    localparam logic [15:0] BEND_CENTER = 16'd8192;
    localparam logic [7:0]  NONE_HELD   = 8'hFF;

    typedef struct packed {
        mnt_kind_t          kind;
        logic [3:0]         channel;
        logic [7:0]         first_data;
        logic [7:0]         second_data;
        logic signed [15:0] bend_value;
    } mnt_decoded_t;

    // Map write requested by a note on or note off
    typedef struct packed {
        logic       wr;
        logic       on;
        logic [7:0] note;
    } mnt_update_t;

    typedef struct packed {
        logic              any_held;
        logic [7:0]        held_count;
        logic signed [7:0] lowest_held;
        logic signed [7:0] highest_held;
    } mnt_summary_t;

endpackage

`default_nettype wire

// File: sv/mnt_msg_if.sv
`default_nettype none

interface mnt_msg_if;
    logic        valid;
    logic        ready;
    logic [23:0] packed_message;
    logic [31:0] timestamp;

    modport source (output valid, output packed_message, output timestamp, input ready);
    modport sink (input valid, input packed_message, input timestamp, output ready);
endinterface

`default_nettype wire

// File: sv/mnt_result_if.sv
`default_nettype none

interface mnt_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         msg_kind;
    logic [3:0]         channel;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic signed [15:0] bend_value;
    logic [31:0]        stamp_out;
    logic               any_held;
    logic [7:0]         held_count;
    logic signed [7:0]  lowest_held;
    logic signed [7:0]  highest_held;

    modport source (
        output valid, input ready,
        output msg_kind, output channel, output first_data, output second_data,
        output bend_value, output stamp_out, output any_held, output held_count,
        output lowest_held, output highest_held
    );
    modport sink (
        input valid, output ready,
        input msg_kind, input channel, input first_data, input second_data,
        input bend_value, input stamp_out, input any_held, input held_count,
        input lowest_held, input highest_held
    );
endinterface

`default_nettype wire

// File: sv/mnt_decode.sv
`default_nettype none

module mnt_decode
    import mnt_pkg::*;
(
    input  wire logic [23:0] packed_message,
    output mnt_decoded_t     decoded,
    output mnt_update_t      update
);

    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [15:0] bend_raw;

    assign status   = packed_message[7:0];
    assign d1       = packed_message[15:8];
    assign d2       = packed_message[23:16];
    assign bend_raw = {1'b0, d2, 7'b0} | {8'b0, d1};

    always_comb
    begin
        decoded.kind        = KIND_UNKNOWN;
        decoded.channel     = status[3:0];
        decoded.first_data  = d1;
        decoded.second_data = d2;
        decoded.bend_value  = '0;
        update.wr           = 1'b0;
        update.on           = 1'b0;
        update.note         = d1;
        unique case (status[7:4])
            STAT_NOTEOFF:
            begin
                decoded.kind = KIND_NOTEOFF;
                update.wr    = 1'b1;
            end
            STAT_NOTEON:
            begin
                // velocity zero releases the note
                decoded.kind = (d2 != 8'd0) ? KIND_NOTEON : KIND_NOTEOFF;
                update.wr    = 1'b1;
                update.on    = (d2 != 8'd0);
            end
            STAT_POLYPRESS:
            begin
                decoded.kind = KIND_POLYPRESS;
            end
            STAT_CC:
            begin
                decoded.kind = KIND_CC;
            end
            STAT_PROGRAM:
            begin
                decoded.kind        = KIND_PROGRAM;
                decoded.second_data = '0;
            end
            STAT_CHANPRESS:
            begin
                decoded.kind        = KIND_CHANPRESS;
                decoded.second_data = '0;
            end
            STAT_BEND:
            begin
                decoded.kind       = KIND_BEND;
                decoded.bend_value = $signed(bend_raw - BEND_CENTER);
            end
            default:
            begin
                decoded.kind        = KIND_UNKNOWN;
                decoded.first_data  = '0;
                decoded.second_data = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/mnt_held_scan.sv
`default_nettype none

module mnt_held_scan
    import mnt_pkg::*;
#(
    parameter int NOTE_SLOTS = 128
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  mnt_update_t update,
    output logic        busy,
    output mnt_summary_t summary
);

    localparam int IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int CNT_W = $clog2(NOTE_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NOTE_SLOTS - 1);
    localparam logic [8:0]       SLOTS_9  = 9'(NOTE_SLOTS);

    logic [NOTE_SLOTS-1:0] map_reg,   map_next;
    logic [NOTE_SLOTS-1:0] map_rot;
    logic                  busy_reg,  busy_next;
    logic [IDX_W-1:0]      pos_reg,   pos_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      low_reg,   low_next;
    logic [IDX_W-1:0]      high_reg,  high_next;
    logic                  in_range;

    // While busy, the map rotates one slot per cycle; slot 0 is the bit under inspection.
    generate
        if (NOTE_SLOTS > 1)
        begin : g_rot
            assign map_rot = {map_reg[0], map_reg[NOTE_SLOTS-1:1]};
        end
        else
        begin : g_norot
            assign map_rot = map_reg;
        end
    endgenerate

    assign in_range = ({1'b0, update.note} < SLOTS_9);

    always_comb
    begin
        map_next   = map_reg;
        busy_next  = busy_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        found_next = found_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        priority if (start)
        begin
            if (update.wr && in_range)
            begin
                map_next[update.note[IDX_W-1:0]] = update.on;
            end
            busy_next  = 1'b1;
            pos_next   = '0;
            count_next = '0;
            found_next = 1'b0;
        end
        else if (busy_reg)
        begin
            map_next = map_rot;
            if (map_reg[0])
            begin
                count_next = count_reg + CNT_W'(1);
                found_next = 1'b1;
                high_next  = pos_reg;
                if (!found_reg)
                begin
                    low_next = pos_reg;
                end
            end
            pos_next = pos_reg + IDX_W'(1);
            // full turn brings the map back to its home position
            if (pos_reg == LAST_POS)
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            // hold the map and the last summary while idle
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            busy_reg  <= 1'b0;
            pos_reg   <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            map_reg   <= map_next;
            busy_reg  <= busy_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
    end

    assign busy                 = busy_reg;
    assign summary.any_held     = found_reg;
    assign summary.held_count   = 8'(count_reg);
    assign summary.lowest_held  = found_reg ? $signed(8'(low_reg)) : $signed(NONE_HELD);
    assign summary.highest_held = found_reg ? $signed(8'(high_reg)) : $signed(NONE_HELD);

endmodule

`default_nettype wire

// File: sv/midi_message_note_tracker_core.sv
`default_nettype none

// MIDI short-message decoder with a held-note tracker. Each transaction on
// msg carries a packed status/data1/data2 message and a timestamp; exactly one
// result transaction follows with the decoded kind, channel, data bytes, pitch
// bend value, the timestamp and a summary of the held-note map after the
// update (any held, count, lowest and highest note, -1 when none). The map of
// NOTE_SLOTS notes is cleared by reset. After a message is taken, the map is
// scanned one note per cycle, and the result is registered once the scan is
// done and the output register is free; the bit-serial scan keeps a further
// message waiting until the previous scan has ended. A new message is taken as
// soon as the previous result has moved into the output register, even while
// that result still waits.
module midi_message_note_tracker_core
    import mnt_pkg::*;
#(
    parameter int NOTE_SLOTS = 128
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    mnt_msg_if.sink      msg,
    mnt_result_if.source result
);

    mnt_decoded_t  decoded;
    mnt_update_t   update;
    mnt_summary_t  summary;
    logic          scan_busy;
    logic          accept;
    logic          load;

    logic          pend_reg,  pend_next;
    logic          valid_reg, valid_next;
    mnt_decoded_t  stage_reg;
    logic [31:0]   stamp_reg;
    mnt_decoded_t  out_dec_reg;
    logic [31:0]   out_stamp_reg;
    mnt_summary_t  out_sum_reg;

    mnt_decode u_decode (
        .packed_message (msg.packed_message),
        .decoded        (decoded),
        .update         (update)
    );

    mnt_held_scan #(
        .NOTE_SLOTS (NOTE_SLOTS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .update  (update),
        .busy    (scan_busy),
        .summary (summary)
    );

    // Move a finished scan into the output register once it is free.
    assign load      = pend_reg && !scan_busy && (!valid_reg || result.ready);
    assign msg.ready = !pend_reg || load;
    assign accept    = msg.valid && msg.ready;

    always_comb
    begin
        pend_next  = pend_reg;
        valid_next = valid_reg;
        if (result.ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            pend_next  = 1'b0;
            valid_next = 1'b1;
        end
        if (accept)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= decoded;
            stamp_reg <= msg.timestamp;
        end
        if (load)
        begin
            out_dec_reg   <= stage_reg;
            out_stamp_reg <= stamp_reg;
            out_sum_reg   <= summary;
        end
    end

    assign result.valid        = valid_reg;
    assign result.msg_kind     = out_dec_reg.kind;
    assign result.channel      = out_dec_reg.channel;
    assign result.first_data   = out_dec_reg.first_data;
    assign result.second_data  = out_dec_reg.second_data;
    assign result.bend_value   = out_dec_reg.bend_value;
    assign result.stamp_out    = out_stamp_reg;
    assign result.any_held     = out_sum_reg.any_held;
    assign result.held_count   = out_sum_reg.held_count;
    assign result.lowest_held  = out_sum_reg.lowest_held;
    assign result.highest_held = out_sum_reg.highest_held;

endmodule

`default_nettype wire
